// ===== rtl/core/indexed_sequence_store_defines.svh =====
// assertion macros for the indexed sequence store checker
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

// clocked assertion with an explicit clock and active-low reset
`define ISQ_ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// assertion on the block clock and reset
`define ISQ_ASSERT(label, prop, msg) \
	`ISQ_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

// ===== rtl/core/isq_pkg.sv =====
// shared types and constants for the indexed sequence store
package isq_pkg;

	localparam int REQ_W          = 3;
	localparam int POS_W          = 9;
	localparam int VAL_W          = 32;
	localparam int STATUS_W       = 2;
	localparam int COUNT_OUT_W    = 9;
	localparam int TDATA_W        = 48;
	localparam int DEFAULT_CAPACITY = 256;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [REQ_W-1:0] REQ_READ     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_POP_LAST = 3'd5;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_READ,
		OP_WRITE,
		OP_INSERT,
		OP_REMOVE,
		OP_APPEND,
		OP_POP_LAST,
		OP_BAD
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t              op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
	} cmd_t;

endpackage

// ===== rtl/core/isq_front.sv =====
// front end: takes request beats and decodes them into commands
module isq_front
	import isq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [REQ_W-1:0] req_type,
	input  logic [POS_W-1:0] position,
	input  logic [VAL_W-1:0] value_in,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output cmd_t             cmd
);

	logic valid_q;
	cmd_t cmd_q;
	op_t  op_dec;

	always_comb begin
		unique case (req_type)
			REQ_READ:     op_dec = OP_READ;
			REQ_WRITE:    op_dec = OP_WRITE;
			REQ_INSERT:   op_dec = OP_INSERT;
			REQ_REMOVE:   op_dec = OP_REMOVE;
			REQ_APPEND:   op_dec = OP_APPEND;
			REQ_POP_LAST: op_dec = OP_POP_LAST;
			default:      op_dec = OP_BAD;
		endcase
	end

	assign in_ready  = !valid_q || cmd_ready;
	assign cmd_valid = valid_q;
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q.op  <= op_dec;
			cmd_q.pos <= position;
			cmd_q.val <= value_in;
		end
	end

endmodule

// ===== rtl/core/isq_cmd_queue.sv =====
// short command queue between the front end and the back end
module isq_cmd_queue
	import isq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           slots_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] fill_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = fill_q != QCW'(QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (do_push && !do_pop) fill_q <= fill_q + QCW'(1);
			else if (do_pop && !do_push) fill_q <= fill_q - QCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== rtl/core/isq_back.sv =====
// back end: entry memory, count, shift sequencer and result register
module isq_back
	import isq_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_pop,
	input  cmd_t                   cmd,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VAL_W-1:0]       out_value,
	output status_t                out_status,
	output logic [COUNT_OUT_W-1:0] out_count
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [VAL_W-1:0] mem [CAPACITY];
	logic [VAL_W-1:0] rdata_q;

	state_t           state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	op_t              op_q;
	logic [AW-1:0]    pos_q;
	logic [VAL_W-1:0] val_q;
	logic [AW-1:0]    idx_q;

	logic                   out_valid_q;
	logic [VAL_W-1:0]       out_value_q;
	status_t                out_status_q;
	logic [COUNT_OUT_W-1:0] out_count_q;

	logic [CMPW-1:0] pos_ext, cnt_ext, cnt_d_ext;
	logic            out_free, start, in_range, ins_range, full, empty, at_end;
	logic            need_fetch, need_shift, more_after_fetch, last_move;
	logic [AW-1:0]   src;

	logic             mem_we, mem_re, res_load, latch_cmd, val_cap, idx_load;
	logic [AW-1:0]    mem_waddr, mem_raddr, idx_d;
	logic [VAL_W-1:0] mem_wdata, res_value;
	status_t          res_status;

	assign pos_ext   = CMPW'(cmd.pos);
	assign cnt_ext   = CMPW'(count_q);
	assign out_free  = !out_valid_q || out_ready;
	assign start     = (state_q == ST_IDLE) && cmd_valid && out_free;
	assign in_range  = pos_ext < cnt_ext;
	assign ins_range = pos_ext <= cnt_ext;
	assign at_end    = pos_ext == cnt_ext;
	assign full      = count_q == CW'(CAPACITY);
	assign empty     = count_q == '0;

	// insert shifts downward from the end, remove shifts upward from the hole
	assign src = (op_q == OP_INSERT) ? idx_q - AW'(1) : idx_q + AW'(1);
	assign more_after_fetch = CW'(pos_q) < count_q;
	assign last_move = (op_q == OP_INSERT) ? (src == pos_q) : !(CW'(src) < count_q);

	assign need_fetch = start && (((cmd.op == OP_READ || cmd.op == OP_REMOVE) && in_range)
		|| (cmd.op == OP_POP_LAST && !empty));
	assign need_shift = start && cmd.op == OP_INSERT && ins_range && !full && !at_end;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (need_fetch) state_d = ST_FETCH;
				else if (need_shift) state_d = ST_MOVE_RD;
			end
			ST_FETCH: begin
				if (op_q != OP_REMOVE) state_d = ST_IDLE;
				else if (more_after_fetch) state_d = ST_MOVE_RD;
				else state_d = ST_DONE;
			end
			ST_MOVE_RD: state_d = ST_MOVE_WR;
			ST_MOVE_WR: state_d = last_move ? ST_DONE : ST_MOVE_RD;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop    = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = AW'(cmd.pos);
		mem_wdata  = cmd.val;
		mem_re     = 1'b0;
		mem_raddr  = AW'(cmd.pos);
		res_load   = 1'b0;
		res_value  = '0;
		res_status = STATUS_OK;
		count_d    = count_q;
		latch_cmd  = 1'b0;
		val_cap    = 1'b0;
		idx_load   = 1'b0;
		idx_d      = AW'(count_q);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						OP_READ: begin
							if (in_range) begin
								mem_re    = 1'b1;
								latch_cmd = 1'b1;
							end else begin
								res_load   = 1'b1;
								res_status = STATUS_RANGE;
							end
						end
						OP_WRITE: begin
							res_load = 1'b1;
							if (in_range) mem_we = 1'b1;
							else res_status = STATUS_RANGE;
						end
						OP_INSERT: begin
							if (!ins_range) begin
								res_load   = 1'b1;
								res_status = STATUS_RANGE;
							end else if (full) begin
								res_load   = 1'b1;
								res_status = STATUS_FULL;
							end else begin
								count_d = count_q + CW'(1);
								if (at_end) begin
									mem_we   = 1'b1;
									res_load = 1'b1;
								end else begin
									latch_cmd = 1'b1;
									idx_load  = 1'b1;
								end
							end
						end
						OP_REMOVE: begin
							if (in_range) begin
								mem_re    = 1'b1;
								latch_cmd = 1'b1;
								count_d   = count_q - CW'(1);
							end else begin
								res_load   = 1'b1;
								res_status = STATUS_RANGE;
							end
						end
						OP_APPEND: begin
							res_load = 1'b1;
							if (full) begin
								res_status = STATUS_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(count_q);
								count_d   = count_q + CW'(1);
							end
						end
						OP_POP_LAST: begin
							if (empty) begin
								res_load   = 1'b1;
								res_status = STATUS_RANGE;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = AW'(count_q - CW'(1));
								latch_cmd = 1'b1;
								count_d   = count_q - CW'(1);
							end
						end
						default: begin
							res_load   = 1'b1;
							res_status = STATUS_RANGE;
						end
					endcase
				end
			end
			ST_FETCH: begin
				if (op_q == OP_REMOVE) begin
					val_cap  = 1'b1;
					idx_load = 1'b1;
					idx_d    = pos_q;
				end else begin
					res_load  = 1'b1;
					res_value = rdata_q;
				end
			end
			ST_MOVE_RD: begin
				mem_re    = 1'b1;
				mem_raddr = src;
			end
			ST_MOVE_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = rdata_q;
				idx_load  = 1'b1;
				idx_d     = src;
			end
			ST_DONE: begin
				res_load = 1'b1;
				if (op_q == OP_INSERT) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q;
					mem_wdata = val_q;
				end else begin
					res_value = val_q;
				end
			end
			default: ;
		endcase
	end

	assign cnt_d_ext = CMPW'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (res_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (latch_cmd) begin
			op_q  <= cmd.op;
			pos_q <= AW'(cmd.pos);
			val_q <= cmd.val;
		end else if (val_cap) begin
			val_q <= rdata_q;
		end
		if (idx_load) idx_q <= idx_d;
		if (res_load) begin
			out_value_q  <= res_value;
			out_status_q <= res_status;
			out_count_q  <= cnt_d_ext[COUNT_OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;
	assign out_count  = out_count_q;

endmodule

// ===== rtl/core/indexed_sequence_store.sv =====
// top level of the indexed sequence store
// Indexed sequence store: an ordered list of up to CAPACITY signed 32-bit
// values kept contiguous from index 0, plus a count. Each request beat on the
// slave side reads, writes, inserts, removes, appends or pops the last value,
// and gives exactly one result beat on the master side carrying the value,
// a status (ok, index out of range or empty, full) and the count afterwards.
// A front stage registers and decodes requests into a two-entry command queue,
// so new beats are taken while the back end is busy or a result waits to be
// taken. The back end owns a single-port entry memory and works one command
// at a time. Write, append and errors finish in the idle state; read and pop
// last add a fetch; insert before the end shifts entries up from the end to
// the position, remove fetches and shifts later entries down, one entry per
// read/write pair through the memory port; a done state then writes the new
// value or returns the removed one. Entries are not cleared at reset, so there
// is no startup pass; only entries below the count are ever read.
module indexed_sequence_store
	import isq_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	// request side
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // position [8:0], value_in [40:9], zero pad
	input  logic [REQ_W-1:0]   s_tuser,   // req_type [2:0]
	// result side
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // value_out [31:0], count_now [40:32], zero pad
	output logic [STATUS_W-1:0] m_tuser   // status [1:0]
);

	localparam int OUT_PAD_W = TDATA_W - VAL_W - COUNT_OUT_W;

	// front to queue
	logic front_valid, front_ready;
	cmd_t front_cmd;
	// queue to back end
	logic q_valid, q_pop;
	cmd_t q_cmd;
	// back end result
	logic [VAL_W-1:0]       res_value;
	status_t                res_status;
	logic [COUNT_OUT_W-1:0] res_count;

	isq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.req_type  (s_tuser),
		.position  (s_tdata[POS_W-1:0]),
		.value_in  (s_tdata[POS_W+VAL_W-1:POS_W]),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	// decouples decode from execution so each side stalls on its own
	isq_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_pop),
		.pop_cmd    (q_cmd)
	);

	isq_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd_pop    (q_pop),
		.cmd        (q_cmd),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (res_value),
		.out_status (res_status),
		.out_count  (res_count)
	);

	// result beat packing
	assign m_tdata = {{OUT_PAD_W{1'b0}}, res_count, res_value};
	assign m_tuser = res_status;

endmodule

// ===== rtl/core/isq_checker.sv =====
// port-level checker for the indexed sequence store, bound to the top level
`include "indexed_sequence_store_defines.svh"

module isq_checker
	import isq_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [TDATA_W-1:0]  s_tdata,
	input logic [REQ_W-1:0]    s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [TDATA_W-1:0]  m_tdata,
	input logic [STATUS_W-1:0] m_tuser
);

	localparam logic [COUNT_OUT_W-1:0] CAP_LOW = COUNT_OUT_W'(CAPACITY);

	logic                        in_beat, out_stall, out_err, out_full, out_code_ok;
	logic [TDATA_W+STATUS_W-1:0] out_beat;
	logic [VAL_W-1:0]            out_value;
	logic [COUNT_OUT_W-1:0]      out_count;

	assign in_beat     = s_tvalid && s_tready;
	assign out_stall   = m_tvalid && !m_tready;
	assign out_err     = m_tvalid && m_tuser != STATUS_OK;
	assign out_full    = m_tvalid && m_tuser == STATUS_FULL;
	assign out_code_ok = m_tuser == STATUS_OK || m_tuser == STATUS_RANGE || m_tuser == STATUS_FULL;
	assign out_beat    = {m_tuser, m_tdata};
	assign out_value   = m_tdata[VAL_W-1:0];
	assign out_count   = m_tdata[VAL_W+COUNT_OUT_W-1:VAL_W];

	// an accepted request beat carries no unknown bits
	`ISQ_ASSERT(a_in_known, in_beat |-> !$isunknown({s_tuser, s_tdata}), "unknown request bits")

	// a stalled result beat holds
	`ISQ_ASSERT(a_out_hold, out_stall |=> m_tvalid && $stable(out_beat), "held beat changed")

	// any error result carries a zero value
	`ISQ_ASSERT(a_err_zero, out_err |-> out_value == '0, "error result with nonzero value")

	// full status only when the count sits at capacity
	`ISQ_ASSERT(a_full_count, out_full |-> out_count == CAP_LOW, "full status below capacity")

	// the reserved status code never shows
	`ISQ_ASSERT(a_status_code, m_tvalid |-> out_code_ok, "reserved status code on result")

endmodule

bind indexed_sequence_store isq_checker #(
	.CAPACITY (CAPACITY)
) u_isq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== sim/indexed_sequence_store_tb.sv =====
// self-checking testbench for the indexed sequence store
`timescale 1ns / 1ps

module indexed_sequence_store_tb;
	import isq_pkg::*;

	localparam int STORE_CAP      = DEFAULT_CAPACITY;
	localparam int RANDOM_ITEMS   = 680;
	localparam int IDLE_PERCENT   = 19;
	// receiver hold-off: starts after this many result beats, lasts this many cycles
	localparam int HOLD_AT        = 150;
	localparam int HOLD_CYCLES    = 400;
	// the worst remove shifts nearly every entry through the back end; a few can queue up
	// ahead of the hold-off, so give it plenty of room
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 32;
	localparam int PAD_W          = TDATA_W - POS_W - VAL_W;

	// request codes the block does not define, expected to come back as range errors
	localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

	logic               clk;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;
	logic [REQ_W-1:0]   s_tuser  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	// set while the sender or the receiver runs a stretch with no idling
	bit sender_calm   = 1'b0;
	bit receiver_calm = 1'b0;

	indexed_sequence_store #(
		.CAPACITY(STORE_CAP)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// scoreboard: keeps its own copy of the row and the count, works out the
	// result of each accepted request and checks result beats in order
	class store_scoreboard;
		typedef struct {
			logic [VAL_W-1:0]       value;
			status_t                status;
			logic [COUNT_OUT_W-1:0] fill;
		} store_result_t;

		logic [VAL_W-1:0] cells [STORE_CAP];
		int unsigned      fill;
		store_result_t    expected_results [$];
		int               errors;
		int               req_seen [8];
		int               full_seen;
		int               range_seen;
		int unsigned      peak_fill;

		function void note_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
				logic [VAL_W-1:0] val);
			store_result_t r;
			int unsigned   i;
			r.value  = '0;
			r.status = STATUS_OK;
			case (req)
				REQ_READ: begin
					if (pos < fill) r.value = cells[pos];
					else r.status = STATUS_RANGE;
				end
				REQ_WRITE: begin
					if (pos < fill) cells[pos] = val;
					else r.status = STATUS_RANGE;
				end
				REQ_INSERT: begin
					// index check wins over the full check
					if (pos > fill) begin
						r.status = STATUS_RANGE;
					end else if (fill >= STORE_CAP) begin
						r.status = STATUS_FULL;
					end else begin
						for (i = fill; i > pos; i--) cells[i] = cells[i - 1];
						cells[pos] = val;
						fill++;
					end
				end
				REQ_REMOVE: begin
					if (pos < fill) begin
						r.value = cells[pos];
						for (i = pos; i + 1 < fill; i++) cells[i] = cells[i + 1];
						fill--;
					end else begin
						r.status = STATUS_RANGE;
					end
				end
				REQ_APPEND: begin
					if (fill >= STORE_CAP) begin
						r.status = STATUS_FULL;
					end else begin
						cells[fill] = val;
						fill++;
					end
				end
				REQ_POP_LAST: begin
					if (fill == 0) begin
						r.status = STATUS_RANGE;
					end else begin
						fill--;
						r.value = cells[fill];
					end
				end
				default: r.status = STATUS_RANGE;
			endcase
			r.fill = fill[COUNT_OUT_W-1:0];
			req_seen[req]++;
			if (r.status == STATUS_FULL) full_seen++;
			if (r.status == STATUS_RANGE) range_seen++;
			if (fill > peak_fill) peak_fill = fill;
			expected_results.push_back(r);
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_result(logic [VAL_W-1:0] value, logic [STATUS_W-1:0] status,
				logic [COUNT_OUT_W-1:0] fill_now);
			store_result_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("result beat with no request outstanding");
				return;
			end
			want = expected_results.pop_front();
			if (value !== want.value)
				report_mismatch($sformatf("value_out %0d, expected %0d",
					$signed(value), $signed(want.value)));
			if (status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
			if (fill_now !== want.fill)
				report_mismatch($sformatf("count_now %0d, expected %0d", fill_now, want.fill));
		endtask

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	store_scoreboard sb = new;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mostly plain random words, now and then the extremes of the signed range
	function automatic logic [VAL_W-1:0] random_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	// index in [0, top], usually close to top so that shifts stay short
	function automatic logic [POS_W-1:0] near_end_pos(int unsigned top);
		int unsigned reach;
		reach = (top < 8) ? top : 8;
		if ($urandom_range(0, 99) < 70) return POS_W'(top - $urandom_range(0, reach));
		return POS_W'($urandom_range(0, top));
	endfunction

	// offer one request beat, note it once accepted, then maybe idle a bit
	task automatic drive_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
			logic [VAL_W-1:0] val);
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {{PAD_W{1'b0}}, val, pos};
		do @(posedge clk); while (!s_tready);
		sb.note_request(req, pos, val);
		if (!sender_calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// result side: take beats with random stalls, one long hold-off to back
	// the block up into its request side
	initial begin : result_sink
		int results_seen = 0;
		bit held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata[VAL_W-1:0], m_tuser,
					m_tdata[VAL_W+COUNT_OUT_W-1:VAL_W]);
				results_seen++;
			end
			receiver_calm = (results_seen >= 400 && results_seen < 550);
			if (!held && results_seen >= HOLD_AT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= receiver_calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// watchdog: gives up when no beat moves on either side for too long
	initial begin : watchdog
		int quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("no beat moved for %0d cycles, giving up", WATCHDOG_LIMIT);
		$display("** indexed_sequence_store: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int               n;
		int               roll;
		int               full_tries = 0;
		bit               growing = 1'b1;
		logic [REQ_W-1:0] req;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each of these requests on an empty store is an error
		drive_request(REQ_POP_LAST, 9'd0, 32'h0);
		drive_request(REQ_READ, 9'd0, 32'h0);
		drive_request(REQ_REMOVE, 9'd0, 32'h0);
		drive_request(REQ_WRITE, 9'd0, 32'h1234_5678);
		drive_request(REQ_INSERT, 9'd1, 32'h1);
		// build a short row with the value extremes, inserts at front, middle and end
		drive_request(REQ_INSERT, 9'd0, 32'h7fff_ffff);
		drive_request(REQ_APPEND, 9'h1ff, 32'h8000_0000);
		drive_request(REQ_INSERT, 9'd2, 32'h0);
		drive_request(REQ_INSERT, 9'd1, 32'hffff_ffff);
		drive_request(REQ_READ, 9'd0, 32'h0);
		drive_request(REQ_READ, 9'd1, 32'h0);
		drive_request(REQ_READ, 9'd2, 32'h0);
		drive_request(REQ_READ, 9'd3, 32'h0);
		// a read one past the end, a write to the last entry, unused codes, all-ones index
		drive_request(REQ_READ, 9'd4, 32'h0);
		drive_request(REQ_WRITE, 9'd3, 32'h5a5a_5a5a);
		drive_request(REQ_UNUSED_6, 9'h1ff, 32'hffff_ffff);
		drive_request(REQ_UNUSED_7, 9'd0, 32'h0);
		drive_request(REQ_INSERT, 9'h1ff, 32'hdead_beef);
		// take the row apart again from the middle and the end
		drive_request(REQ_REMOVE, 9'd1, 32'h0);
		drive_request(REQ_REMOVE, 9'd2, 32'h0);
		drive_request(REQ_POP_LAST, 9'h1ff, 32'h0);
		drive_request(REQ_POP_LAST, 9'd0, 32'h0);
		drive_request(REQ_POP_LAST, 9'd0, 32'h0);

		// sender pause: let every outstanding result drain
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(posedge clk);

		// random: fill the store up to capacity, knock on it while full,
		// then empty it again, with reads, writes and noise mixed in
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			sender_calm = (n >= 300 && n < 450);
			if (sb.fill == 0) begin
				growing = 1'b1;
			end else if (sb.fill >= STORE_CAP && full_tries >= 4) begin
				growing    = 1'b0;
				full_tries = 0;
			end
			roll = $urandom_range(0, 99);
			val  = random_value();
			pos  = POS_W'($urandom_range(0, 2 ** POS_W - 1));
			if (roll < 5) begin
				req = REQ_W'($urandom_range(0, 2 ** REQ_W - 1));
			end else if (roll < 85) begin
				if (growing) begin
					if (sb.fill >= STORE_CAP) full_tries++;
					if ($urandom_range(0, 1)) begin
						req = REQ_APPEND;
					end else begin
						req = REQ_INSERT;
						pos = near_end_pos(sb.fill);
					end
				end else begin
					if ($urandom_range(0, 1)) begin
						req = REQ_POP_LAST;
					end else begin
						req = REQ_REMOVE;
						pos = near_end_pos(sb.fill - 1);
					end
				end
			end else begin
				req = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
				pos = (sb.fill == 0) ? '0 : POS_W'($urandom_range(0, sb.fill - 1));
			end
			drive_request(req, pos, val);
		end
		sender_calm = 1'b0;
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("request mix: rd %0d wr %0d ins %0d rm %0d app %0d pop %0d bad %0d",
			sb.req_seen[REQ_READ], sb.req_seen[REQ_WRITE], sb.req_seen[REQ_INSERT],
			sb.req_seen[REQ_REMOVE], sb.req_seen[REQ_APPEND], sb.req_seen[REQ_POP_LAST],
			sb.req_seen[REQ_UNUSED_6] + sb.req_seen[REQ_UNUSED_7]);
		$display("peak fill %0d of %0d, full status %0d, range status %0d, mismatches %0d",
			sb.peak_fill, STORE_CAP, sb.full_seen, sb.range_seen, sb.errors);
		if (sb.errors == 0) begin
			$display("** indexed_sequence_store: PASSED **");
		end else begin
			$display("** indexed_sequence_store: FAILED **");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/isq_pkg.sv
rtl/core/isq_front.sv
rtl/core/isq_cmd_queue.sv
rtl/core/isq_back.sv
rtl/core/indexed_sequence_store.sv
rtl/core/isq_checker.sv
sim/indexed_sequence_store_tb.sv
